[rtl/rolling_hash_substring_matcher_macros.svh]
// Assertion helpers shared by the checker file of the substring matcher.
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_MACROS_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define RHSM_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define RHSM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rhsm_pkg.sv]
package rhsm_pkg;

    // Fixed widths of the configuration and the payload fields.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int HASH_W     = 32;
    localparam int POS_W      = 32;
    localparam int BYTE_W     = 8;

    // The pattern registers hold at most sixteen bytes.
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_start;
        logic             any_match;
        logic             text_done;
    } out_item_t;

endpackage

[rtl/rolling_hash_substring_matcher.sv]
// Channel   Direction  Handshake            Beat payload
// in        sink       in_valid / in_stall  text_byte, end_of_text
// out       source     out_valid/out_stall  match_found, match_start, any_match, text_done
// cfg       sink       cfg_write            cfg_index selects the register, cfg_data its value
//
// One text byte is taken per cycle while in_stall is low; its result is ready in the output register in the next cycle.
// The rolling hash update, the hash compare and the byte compare all sit between the input
// handshake and that register. After reset and after every configuration write, in_stall is
// high while one multiply-add step rebuilds the pattern hash and the window weight over the
// active pattern length (1 to 16), one pattern byte per cycle.
// A stalled output holds its beat, and once the sequencer is idle the input keeps flowing
// whenever the output register is empty or is being emptied in the same cycle.
module rolling_hash_substring_matcher #(
    parameter int MAX_PATTERN = 16,
    parameter int HASH_BASE   = 101
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rhsm_pkg::in_item_t                   in_data,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rhsm_pkg::out_item_t                  out_data,

    input  logic                                 cfg_write,
    input  logic [rhsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rhsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import rhsm_pkg::*;

    // The longest usable pattern is bounded both by the window and by the pattern registers.
    localparam int LIM    = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FILL_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam logic [HASH_W-1:0] BASE = HASH_W'(HASH_BASE);

    // The pattern sequencer is either finished or still folding pattern bytes in.
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_LOAD = 2'b10
    } seq_state_t;

    // Configuration registers.
    logic [LEN_W-1:0]      cfg_len_reg;
    logic [CFG_DATA_W-1:0] cfg_low_reg;
    logic [CFG_DATA_W-1:0] cfg_high_reg;

    // Pattern sequencer.
    seq_state_t            seq_state_reg;
    seq_state_t            seq_state_next;
    logic [PAT_IDX_W-1:0]  seq_k_reg;
    logic [PAT_IDX_W-1:0]  seq_k_next;
    logic [HASH_W-1:0]     phash_reg;
    logic [HASH_W-1:0]     phash_next;
    logic [HASH_W-1:0]     topb_reg;
    logic [HASH_W-1:0]     topb_next;

    // Pattern bytes lined up against the window, newest window byte at entry 0.
    logic [BYTE_W-1:0]     exp_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]     exp_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] mask_reg;
    logic [MAX_PATTERN-1:0] mask_next;

    // Per-text state.
    logic [BYTE_W-1:0]     store_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0]     store_next [MAX_PATTERN];
    logic [HASH_W-1:0]     whash_reg;
    logic [HASH_W-1:0]     whash_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic                  seen_reg;
    logic                  seen_next;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_data_reg;
    out_item_t             out_data_next;

    logic [BYTE_W-1:0]     pat [PAT_BYTES];
    logic [LEN_W-1:0]      len;
    logic [LEN_W-1:0]      len_m1;
    logic [CMP_W-1:0]      len_c;
    logic                  in_fire;
    logic                  full_before;
    logic                  full_after;
    logic [HASH_W-1:0]     leave_prod;
    logic                  bytes_eq;
    logic                  hit;

    // The two pattern registers seen as one row of sixteen bytes.
    always_comb
    begin
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            if (k < PAT_BYTES / 2)
            begin
                pat[k] = cfg_low_reg[BYTE_W*k +: BYTE_W];
            end
            else
            begin
                pat[k] = cfg_high_reg[BYTE_W*(k - PAT_BYTES / 2) +: BYTE_W];
            end
        end
    end

    // A length of zero counts as one, and anything past the limit is clipped.
    always_comb
    begin
        len = cfg_len_reg;
        if (len == '0)
        begin
            len = LEN_W'(1);
        end
        if (len > LEN_W'(LIM))
        begin
            len = LEN_W'(LIM);
        end
        len_m1 = len - LEN_W'(1);
        len_c  = CMP_W'(len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg  <= LEN_W'(1);
            cfg_low_reg  <= '0;
            cfg_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: cfg_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:    cfg_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   cfg_high_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The sequencer builds the pattern hash by Horner's rule and, alongside it, BASE to the
    // power of the length. The window update uses that power directly, so the oldest byte's
    // weight is removed in the same step as the shift by BASE.
    always_comb
    begin
        seq_state_next = seq_state_reg;
        seq_k_next     = seq_k_reg;
        unique case (seq_state_reg)
            SEQ_IDLE:
            begin
                seq_k_next = '0;
            end
            SEQ_LOAD:
            begin
                if (seq_k_reg == PAT_IDX_W'(len_m1))
                begin
                    seq_state_next = SEQ_IDLE;
                    seq_k_next     = '0;
                end
                else
                begin
                    seq_k_next = seq_k_reg + PAT_IDX_W'(1);
                end
            end
            default:
            begin
                seq_state_next = SEQ_LOAD;
                seq_k_next     = '0;
            end
        endcase
        // A new write restarts the sweep against the updated registers.
        if (cfg_write)
        begin
            seq_state_next = SEQ_LOAD;
            seq_k_next     = '0;
        end
    end

    always_comb
    begin
        phash_next = ((seq_k_reg == '0) ? '0 : phash_reg) * BASE
                   + HASH_W'(pat[seq_k_reg]);
        topb_next  = ((seq_k_reg == '0) ? HASH_W'(1) : topb_reg) * BASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_LOAD;
            seq_k_reg     <= '0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            seq_k_reg     <= seq_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_state_reg == SEQ_LOAD)
        begin
            phash_reg <= phash_next;
            topb_reg  <= topb_next;
        end
    end

    // Window entry j holds the byte that pattern byte len-1-j must equal. These registers
    // follow the configuration every cycle and settle while the sequencer holds the input off.
    always_comb
    begin
        logic [PAT_IDX_W-1:0] sel;
        sel = '0;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            exp_next[j]  = '0;
            mask_next[j] = 1'b0;
            if (j < int'(len))
            begin
                sel          = PAT_IDX_W'(len_m1 - LEN_W'(j));
                exp_next[j]  = pat[sel];
                mask_next[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        mask_reg <= mask_next;
    end

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (seq_state_reg != SEQ_IDLE) || (out_valid_reg && out_stall);

    // Rolling hash: drop the oldest byte's term once the window is full, then shift in the
    // new byte. The two products are independent and meet only in the final sum.
    assign full_before = CMP_W'(fill_reg) >= len_c;
    assign leave_prod  = full_before
                       ? HASH_W'(store_reg[IDX_W'(len_m1)]) * topb_reg
                       : '0;

    always_comb
    begin
        store_next[0] = in_data.text_byte;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            store_next[j] = store_reg[j-1];
        end
        whash_next = whash_reg * BASE - leave_prod + HASH_W'(in_data.text_byte);
        fill_next  = (fill_reg < FILL_W'(MAX_PATTERN)) ? fill_reg + FILL_W'(1) : fill_reg;
    end

    assign full_after = CMP_W'(fill_next) >= len_c;

    // Entries beyond the pattern length are masked out of the compare.
    always_comb
    begin
        bytes_eq = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (mask_reg[j] && (store_next[j] != exp_reg[j]))
            begin
                bytes_eq = 1'b0;
            end
        end
    end

    assign hit = full_after && (whash_next == phash_reg) && bytes_eq;

    always_comb
    begin
        pos_next  = pos_reg + POS_W'(1);
        seen_next = seen_reg || hit;
        out_data_next.match_found = hit;
        out_data_next.match_start = hit ? (pos_reg - POS_W'(len_m1)) : '0;
        out_data_next.any_match   = in_data.end_of_text && seen_next;
        out_data_next.text_done   = in_data.end_of_text;
    end

    // Window entries at or past the fill count never affect a result, so the store needs no clear.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            store_reg <= store_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whash_reg <= '0;
            pos_reg   <= '0;
            fill_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            if (in_data.end_of_text)
            begin
                whash_reg <= '0;
                pos_reg   <= '0;
                fill_reg  <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                whash_reg <= whash_next;
                pos_reg   <= pos_next;
                fill_reg  <= fill_next;
                seen_reg  <= seen_next;
            end
        end
    end

    // The output register reloads on every accepted byte; in_stall already covers a full,
    // stalled register, so a held beat is never overwritten.
    assign out_valid_next = in_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/rhsm_checker.sv]
`include "rolling_hash_substring_matcher_macros.svh"

module rhsm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  rhsm_pkg::out_item_t             out_data,
    input  logic                            cfg_write
);

    // A start index is only reported together with a match.
    `RHSM_CHECK(a_start_needs_match, out_valid && !out_data.match_found, out_data.match_start == '0, "match_start set without a match")

    // The summary flag belongs to the last beat of a text.
    `RHSM_CHECK(a_any_only_at_end, out_valid && out_data.any_match, out_data.text_done, "any_match outside the last beat")

    // A match on the last byte must show in the summary of that text.
    `RHSM_CHECK(a_last_match_counted, out_valid && out_data.text_done && out_data.match_found, out_data.any_match, "match on the last byte not counted")

    // A configuration write reloads the pattern hash, and input is held meanwhile.
    `RHSM_CHECK_NEXT(a_cfg_holds_input, cfg_write, in_stall, "input open right after a configuration write")

    // A stalled result beat stays in place.
    `RHSM_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind rolling_hash_substring_matcher rhsm_checker u_rhsm_checker (.*);
